FILE: design/png_unf_pkg.sv
// Shared constants for the PNG row unfilter: field widths, line store size
// and filter type codes. No dependencies.
package png_unf_pkg;

   localparam int MAX_ROW_BYTES = 4096;
   localparam int COL_W         = $clog2(MAX_ROW_BYTES);
   localparam int WIDTH_W       = 13;
   localparam int PIXEL_W       = 8;
   localparam int KIND_W        = 3;

   localparam logic [KIND_W-1:0] FILT_NONE  = 3'd0;
   localparam logic [KIND_W-1:0] FILT_SUB   = 3'd1;
   localparam logic [KIND_W-1:0] FILT_UP    = 3'd2;
   localparam logic [KIND_W-1:0] FILT_AVG   = 3'd3;
   localparam logic [KIND_W-1:0] FILT_PAETH = 3'd4;

endpackage

FILE: design/png_unf_if.sv
// Valid/ready channel interfaces for the PNG row unfilter: byte stream in,
// pixel bytes out. Depends on png_unf_pkg.
interface png_unf_req_if;
   logic                                valid;
   logic                                ready;
   logic [png_unf_pkg::PIXEL_W-1:0]     stream_byte;
   logic                                image_start;

   modport source (output valid, stream_byte, image_start, input ready);
   modport sink   (input valid, stream_byte, image_start, output ready);
endinterface

interface png_unf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [png_unf_pkg::PIXEL_W-1:0]     pixel_byte;
   logic [png_unf_pkg::COL_W-1:0]       column;
   logic                                row_end;

   modport source (output valid, pixel_byte, column, row_end, input ready);
   modport sink   (input valid, pixel_byte, column, row_end, output ready);
endinterface

FILE: design/png_row_unfilter.sv
// PNG scanline unfilter top level: row bookkeeping, line store, predictor.
// Depends on png_unf_pkg and the channel interfaces in png_unf_if.sv.
//
// Usage:
//   req_bus carries the inflated stream, one byte per word. The first word of
//   each row is the filter type (None, Sub, Up, Average, Paeth; codes above
//   Paeth act as None) and gives no result. The next row_width words are
//   filtered data, each giving one word on rsp_bus: the pixel byte, its
//   column and a row_end flag on the last byte of the row. image_start on a
//   word abandons any row in progress, takes that word as a filter type and
//   makes the row that follows read zeros as its upper neighbors.
//   csr_write_enable/csr_write_data set row_width (0 acts as 1, above 4096
//   acts as 4096); write it only while the block is idle.
// Timing:
//   One word per cycle sustained while rsp_bus is ready. An accepted data
//   word reaches rsp_bus from stage one via the output register (two-stage
//   pipe: stage one holds it during the line store read, then the predictor
//   fills the output register). Left-neighbor feedback closes in stage one.
// Reset:
//   Synchronous, active high. Expect a filter byte, start a first row,
//   row_width = 320. The line store is not cleared.
// Stall:
//   When rsp_bus is not ready the output register holds, stage one holds
//   behind it and a full stage one drops req_bus.ready; no word is lost.
module png_row_unfilter (
   input  logic                             clock,
   input  logic                             reset,
   png_unf_req_if.sink                      req_bus,
   png_unf_rsp_if.source                    rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [png_unf_pkg::WIDTH_W-1:0]  csr_write_data
);
   import png_unf_pkg::*;

   // Paeth predictor on one byte triple.
   function automatic logic [PIXEL_W-1:0] paeth_pred(input logic [PIXEL_W-1:0] a,
                                                     input logic [PIXEL_W-1:0] b,
                                                     input logic [PIXEL_W-1:0] c);
      logic [PIXEL_W+1:0] pa, pb, pc, sum_ab, dbl_c;
      pa     = (b >= c) ? {2'b00, b - c} : {2'b00, c - b};
      pb     = (a >= c) ? {2'b00, a - c} : {2'b00, c - a};
      sum_ab = {2'b00, a} + {2'b00, b};
      dbl_c  = {2'b00, c} + {2'b00, c};
      pc     = (sum_ab >= dbl_c) ? sum_ab - dbl_c : dbl_c - sum_ab;
      if (pa <= pb && pa <= pc) begin
         paeth_pred = a;
      end else if (pb <= pc) begin
         paeth_pred = b;
      end else begin
         paeth_pred = c;
      end
   endfunction

   // Configuration
   logic [WIDTH_W-1:0] row_width_ff;
   logic [WIDTH_W-1:0] width_eff;

   // Row bookkeeping, updated at acceptance
   logic [WIDTH_W-1:0] position_ff, position_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic               first_row_ff, first_row_in;

   // Stage one: accepted data byte waiting for line store data
   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_byte_ff;
   logic [KIND_W-1:0]  s1_kind_ff;
   logic               s1_first_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_last_ff;

   // Neighbor values for the predictor
   logic [PIXEL_W-1:0] left_ff, left_in;
   logic [PIXEL_W-1:0] upleft_ff, upleft_in;

   // Line store
   logic [PIXEL_W-1:0] line_mem [MAX_ROW_BYTES];
   logic [PIXEL_W-1:0] above_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic               rsp_end_ff;

   logic               out_free, s1_free, s1_move, req_take;
   logic               is_filter, is_last;
   logic [COL_W-1:0]   col_now;
   logic [PIXEL_W-1:0] above, pred, result;
   logic [PIXEL_W:0]   avg_sum;

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (row_width_ff > WIDTH_W'(MAX_ROW_BYTES)) begin
         width_eff = WIDTH_W'(MAX_ROW_BYTES);
      end else begin
         width_eff = row_width_ff;
      end
   end

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_move       = s1_valid_ff && out_free;
   assign s1_free       = !s1_valid_ff || out_free;
   assign req_bus.ready = s1_free;
   assign req_take      = req_bus.valid && s1_free;

   // Classify the incoming word: image_start forces a filter byte.
   assign is_filter = req_bus.image_start || (position_ff == '0);
   assign col_now   = COL_W'(position_ff - WIDTH_W'(1));
   assign is_last   = (position_ff >= width_eff);

   always_comb begin
      position_in  = position_ff;
      kind_in      = kind_ff;
      first_row_in = first_row_ff;
      if (req_take) begin
         if (is_filter) begin
            kind_in     = (req_bus.stream_byte > PIXEL_W'(FILT_PAETH)) ?
                          FILT_NONE : KIND_W'(req_bus.stream_byte);
            position_in = WIDTH_W'(1);
            if (req_bus.image_start) begin
               first_row_in = 1'b1;
            end
         end else if (is_last) begin
            position_in  = '0;
            first_row_in = 1'b0;
         end else begin
            position_in = position_ff + WIDTH_W'(1);
         end
      end
   end

   // Predictor on the word in stage one.
   assign above   = s1_first_ff ? '0 : above_ff;
   assign avg_sum = {1'b0, left_ff} + {1'b0, above};

   always_comb begin
      unique case (s1_kind_ff)
         FILT_SUB:   pred = left_ff;
         FILT_UP:    pred = above;
         FILT_AVG:   pred = avg_sum[PIXEL_W:1];
         FILT_PAETH: pred = paeth_pred(left_ff, above, upleft_ff);
         default:    pred = '0;
      endcase
   end

   assign result = s1_byte_ff + pred;

   // A filter byte clears the neighbors, overriding a byte leaving stage one.
   always_comb begin
      left_in   = left_ff;
      upleft_in = upleft_ff;
      if (req_take && is_filter) begin
         left_in   = '0;
         upleft_in = '0;
      end else if (s1_move) begin
         left_in   = result;
         upleft_in = above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_W'(320);
         position_ff  <= '0;
         kind_ff      <= FILT_NONE;
         first_row_ff <= 1'b1;
         left_ff      <= '0;
         upleft_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            row_width_ff <= csr_write_data;
         end
         position_ff  <= position_in;
         kind_ff      <= kind_in;
         first_row_ff <= first_row_in;
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
         if (s1_free) begin
            s1_valid_ff <= req_take && !is_filter;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Stage one payload: latch the word with its row context.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_bus.stream_byte;
         s1_kind_ff  <= kind_ff;
         s1_first_ff <= first_row_ff;
         s1_col_ff   <= col_now;
         s1_last_ff  <= is_last;
      end
   end

   // Line store: read the column on acceptance, write the result on advance.
   always_ff @(posedge clock) begin
      if (req_take) begin
         above_ff <= line_mem[col_now];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         line_mem[s1_col_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_pixel_ff <= result;
         rsp_col_ff   <= s1_col_ff;
         rsp_end_ff   <= s1_last_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_byte = rsp_pixel_ff;
   assign rsp_bus.column     = rsp_col_ff;
   assign rsp_bus.row_end    = rsp_end_ff;

   // Position never runs past the longest row.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      position_ff <= WIDTH_W'(MAX_ROW_BYTES))
      else $error("row position beyond line store");

   // Stage one blocked by a full output register must refuse input.
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while stage one is blocked");

   // The last data byte of a row returns to expecting a filter byte.
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_take && !is_filter && is_last) |=> (position_ff == '0 && !first_row_ff))
      else $error("row did not wrap after last byte");

   // A filter byte never enters stage one.
   a_filter_drop: assert property (@(posedge clock) disable iff (reset)
      (req_take && is_filter) |=> !s1_valid_ff)
      else $error("filter byte entered stage one");

endmodule
